@@ hw/rtl/sss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the staggered spin-up scheduler
// Item codes, result codes, power states and register indexes.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned NumDevices = 16;
  localparam int unsigned DevW       = 4;
  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned FifoW      = 4;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [1:0] {
    FUNC_CMD  = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_SET  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_PROCEED = 3'd0,
    KIND_BLOCKED = 3'd1,
    KIND_UNBLOCK = 3'd2,
    KIND_PASSED  = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  localparam logic [2:0] PS_STANDBY = 3'd1;
  localparam logic [2:0] PS_PASSED  = 3'd2;
  localparam logic [2:0] PS_WAITING = 3'd3;
  localparam logic [2:0] PS_SPIN    = 3'd4;
  localparam logic [2:0] PS_SBWAIT  = 3'd5;

  localparam logic [1:0] REG_MAX_CONC = 2'd0;
  localparam logic [1:0] REG_SPINUP   = 2'd1;
  localparam logic [1:0] REG_STANDBY  = 2'd2;

  // Classified operation handed from front to back.
  typedef struct packed {
    func_e       func;
    logic [3:0]  device;
    logic [2:0]  new_state;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

endpackage

@@ hw/rtl/sss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_front: input acceptance and op queue
// Takes input transfers into a short queue that the back end drains.
// ----------------------------------------------------------------------------
module sss_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     func_i,
  input  logic [3:0]     device_i,
  input  logic [2:0]     new_state_i,
  output logic           op_valid_o,
  output sss_pkg::op_t   op_o,
  input  logic           op_take_i
);

  sss_pkg::op_t q_mem_q [sss_pkg::QDepth];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'(sss_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_mem_q[rd_q];

  always_comb begin
    rd_d  = rd_q + 1'(op_take_i);
    wr_d  = wr_q + 1'(push);
    cnt_d = cnt_q + 2'(push) - 2'(op_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= '{func: sss_pkg::func_e'(func_i), device: device_i,
                         new_state: new_state_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(sss_pkg::QDepth)) else $error("op queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_take_i |-> op_valid_o) else $error("take from empty op queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !op_take_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");

endmodule

@@ hw/rtl/sss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_back: scheduler engine
// Holds device state, timers, wait FIFO and slot count; scans one device per
// cycle on a tick, unless a pending result waits to be sent, and presents results through an output register.
// ----------------------------------------------------------------------------
module sss_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          op_valid_i,
  input  sss_pkg::op_t  op_i,
  output logic          op_take_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    kind_o,
  output logic [3:0]    device_res_o,
  output logic          last_o
);

  localparam int unsigned N = sss_pkg::NumDevices;

  logic [4:0]  max_q;
  logic [7:0]  spin_t_q;
  logic [15:0] sb_t_q;

  logic [2:0]  ps_q    [N];
  logic [N-1:0] sarm_q, barm_q, fresh_q;
  logic [7:0]  scnt_q  [N];
  logic [15:0] bcnt_q  [N];
  logic [3:0]  fifo_q  [sss_pkg::FifoDepth];
  logic [3:0]  head_q, tail_q;
  logic [4:0]  fcnt_q, slots_q;

  sss_pkg::back_state_e st_q, st_d;
  logic [3:0]  idx_q;
  // last device step of the scan has been carried out
  logic        scan_end_q;
  // pending per-device results of the current scan step
  logic        p_unb_q, p_pas_q;
  logic [3:0]  p_udev_q;

  logic        ov_q;
  logic [2:0]  okind_q;
  logic [3:0]  odev_q;
  logic        olast_q;

  logic        out_free;
  assign out_free     = !ov_q || !out_stall_i;
  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign device_res_o = odev_q;
  assign last_o       = olast_q;

  // scan step decode for device idx_q
  logic        s_exp, b_exp, grant_ok;
  logic [4:0]  slots_rel;
  logic [3:0]  gdev;
  always_comb begin
    s_exp     = sarm_q[idx_q] && !fresh_q[idx_q] && (scnt_q[idx_q] <= 8'd1);
    b_exp     = barm_q[idx_q] && (bcnt_q[idx_q] <= 16'd1);
    slots_rel = (slots_q != 5'd0) ? slots_q - 5'd1 : 5'd0;
    grant_ok  = s_exp && (fcnt_q != 5'd0) && (slots_rel < max_q);
    gdev      = fifo_q[head_q];
  end

  // command decode
  logic        c_sleep, c_free, c_room;
  always_comb begin
    c_sleep = (ps_q[op_i.device] == sss_pkg::PS_STANDBY) ||
              (ps_q[op_i.device] == sss_pkg::PS_PASSED);
    c_free  = slots_q < max_q;
    c_room  = fcnt_q < 5'(sss_pkg::FifoDepth);
  end

  always_comb begin
    st_d      = st_q;
    op_take_o = 1'b0;
    unique case (st_q)
      sss_pkg::ST_IDLE: begin
        if (op_valid_i && out_free) begin
          op_take_o = (op_i.func != sss_pkg::FUNC_TICK);
          if (op_i.func == sss_pkg::FUNC_TICK) st_d = sss_pkg::ST_SCAN;
        end
      end
      sss_pkg::ST_SCAN: begin
        // leave once the last device is done and nothing is left to send
        if (!p_unb_q && !p_pas_q) begin
          if (scan_end_q || (idx_q == 4'(N - 1) && !b_exp && !grant_ok))
            st_d = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_EMIT: begin
        if (out_free) begin
          op_take_o = 1'b1;
          st_d      = sss_pkg::ST_IDLE;
        end
      end
      default: st_d = sss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sss_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= 5'd2;
      spin_t_q <= 8'd6;
      sb_t_q  <= 16'd0;
      sarm_q  <= '0;
      barm_q  <= '0;
      fresh_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fcnt_q  <= '0;
      slots_q <= '0;
      idx_q   <= '0;
      scan_end_q <= 1'b0;
      p_unb_q <= 1'b0;
      p_pas_q <= 1'b0;
      p_udev_q <= '0;
      ov_q    <= 1'b0;
      okind_q <= '0;
      odev_q  <= '0;
      olast_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        ps_q[i]   <= '0;
        scnt_q[i] <= '0;
        bcnt_q[i] <= '0;
      end
    end else begin
      if (out_free) ov_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sss_pkg::REG_MAX_CONC: max_q    <= cfg_data_i[4:0];
          sss_pkg::REG_SPINUP:   spin_t_q <= cfg_data_i[7:0];
          sss_pkg::REG_STANDBY:  sb_t_q   <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        sss_pkg::ST_IDLE: begin
          idx_q   <= '0;
          fresh_q <= '0;
          scan_end_q <= 1'b0;
          if (op_valid_i && out_free && op_i.func != sss_pkg::FUNC_TICK) begin
            ov_q    <= 1'b1;
            olast_q <= 1'b1;
            odev_q  <= (op_i.func == sss_pkg::FUNC_CMD) ? op_i.device : 4'd0;
            okind_q <= sss_pkg::KIND_DONE;
            if (op_i.func == sss_pkg::FUNC_SET) begin
              ps_q[op_i.device] <= op_i.new_state;
            end else if (op_i.func == sss_pkg::FUNC_CMD) begin
              okind_q <= sss_pkg::KIND_PROCEED;
              if (c_sleep) begin
                if (c_free) begin
                  slots_q <= slots_q + 5'd1;
                  ps_q[op_i.device]   <= sss_pkg::PS_SPIN;
                  sarm_q[op_i.device] <= 1'b1;
                  scnt_q[op_i.device] <= spin_t_q;
                end else begin
                  okind_q <= sss_pkg::KIND_BLOCKED;
                  if (c_room) begin
                    fifo_q[tail_q] <= op_i.device;
                    tail_q <= tail_q + 4'd1;
                    fcnt_q <= fcnt_q + 5'd1;
                    ps_q[op_i.device] <= sss_pkg::PS_WAITING;
                  end
                end
              end else if (ps_q[op_i.device] == sss_pkg::PS_SBWAIT) begin
                barm_q[op_i.device] <= 1'b1;
                bcnt_q[op_i.device] <= sb_t_q;
              end
            end
          end
        end
        sss_pkg::ST_SCAN: begin
          if (p_unb_q || p_pas_q) begin
            if (out_free) begin
              ov_q    <= 1'b1;
              olast_q <= 1'b0;
              if (p_unb_q) begin
                okind_q <= sss_pkg::KIND_UNBLOCK;
                odev_q  <= p_udev_q;
                p_unb_q <= 1'b0;
              end else begin
                okind_q <= sss_pkg::KIND_PASSED;
                odev_q  <= idx_q;
                p_pas_q <= 1'b0;
                idx_q   <= idx_q + 4'd1;
                if (idx_q == 4'(N - 1)) scan_end_q <= 1'b1;
              end
            end
          end else if (!scan_end_q) begin
            if (sarm_q[idx_q] && !fresh_q[idx_q]) begin
              if (s_exp) begin
                sarm_q[idx_q] <= 1'b0;
                scnt_q[idx_q] <= 8'd0;
                slots_q <= slots_rel;
                if (grant_ok) begin
                  head_q  <= head_q + 4'd1;
                  fcnt_q  <= fcnt_q - 5'd1;
                  slots_q <= slots_rel + 5'd1;
                  ps_q[gdev]    <= sss_pkg::PS_SPIN;
                  sarm_q[gdev]  <= 1'b1;
                  scnt_q[gdev]  <= spin_t_q;
                  fresh_q[gdev] <= 1'b1;
                  p_unb_q  <= 1'b1;
                  p_udev_q <= gdev;
                end
              end else begin
                scnt_q[idx_q] <= scnt_q[idx_q] - 8'd1;
              end
            end
            if (barm_q[idx_q]) begin
              if (b_exp) begin
                barm_q[idx_q] <= 1'b0;
                bcnt_q[idx_q] <= 16'd0;
                ps_q[idx_q]   <= sss_pkg::PS_PASSED;
                p_pas_q <= 1'b1;
              end else begin
                bcnt_q[idx_q] <= bcnt_q[idx_q] - 16'd1;
              end
            end
            // a standby result holds the index until it has been sent
            if (!b_exp) begin
              idx_q <= idx_q + 4'd1;
              if (idx_q == 4'(N - 1)) scan_end_q <= 1'b1;
            end
          end
        end
        sss_pkg::ST_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            olast_q <= 1'b1;
            okind_q <= sss_pkg::KIND_DONE;
            odev_q  <= 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(okind_q) && $stable(odev_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= 5'(sss_pkg::FifoDepth)) else $error("wait fifo overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sss_pkg::ST_IDLE) |-> !p_unb_q && !p_pas_q)
    else $error("pending result left after scan");

endmodule

@@ hw/rtl/staggered_spinup_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_spinup_scheduler: staggered disk spin-up scheduler
// Caps concurrent spin-ups, queues waiting disks, runs per-disk timers.
// ----------------------------------------------------------------------------
// Command / set-state: the item passes the op queue, then its result is
//   registered in the output register. Tick: all 16 devices are scanned in
//   turn, each unblock/standby result is sent as it arises, then a done result.
// Throughput: one item at a time in the engine; a two-entry op queue lets
//   input transfers continue while the engine scans.
// Reset: asynchronous, clears all device state, timers, FIFO pointers and
//   loads register defaults (max 2, spin-up 6, standby 0).
// ----------------------------------------------------------------------------
module staggered_spinup_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  device_i,
  input  logic [2:0]  new_state_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  device_res_o,
  output logic        last_o
);

  // front to back op hand-off
  logic         op_valid, op_take;
  sss_pkg::op_t op;

  sss_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .device_i, .new_state_i,
    .op_valid_o(op_valid), .op_o(op), .op_take_i(op_take)
  );

  // engine: each command is handled directly in the idle state, ticks scan all devices in turn
  sss_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_valid_i(op_valid), .op_i(op), .op_take_o(op_take),
    .out_valid_o, .out_stall_i, .kind_o, .device_res_o, .last_o
  );

endmodule

@@ test/tb_staggered_spinup_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staggered_spinup_scheduler: self-checking bench for the spin-up scheduler
// Drives commands, ticks and set-state items with random idling and stalls,
// predicts every result from an internal copy of the scheduler state and
// compares each output transfer with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_staggered_spinup_scheduler;

  typedef struct packed {
    sss_pkg::kind_e kind;
    logic [3:0]     dev;
    logic           last;
  } res_t;

  // Scoreboard: shadow scheduler state plus the queue of pending results.
  class spinup_scoreboard;
    logic [4:0]  max_conc;
    logic [7:0]  spin_len;
    logic [15:0] sb_len;
    logic [2:0]  pstate  [sss_pkg::NumDevices];
    bit          spin_on [sss_pkg::NumDevices];
    logic [7:0]  spin_cnt[sss_pkg::NumDevices];
    bit          sb_on   [sss_pkg::NumDevices];
    logic [15:0] sb_cnt  [sss_pkg::NumDevices];
    logic [3:0]  waitq   [sss_pkg::FifoDepth];
    int unsigned q_head, q_tail, q_count, slots;
    res_t        pending[$];
    int          errors;

    function void clear();
      max_conc = 2; spin_len = 6; sb_len = 0;
      for (int i = 0; i < sss_pkg::NumDevices; i++) begin
        pstate[i] = 0; spin_on[i] = 0; spin_cnt[i] = 0;
        sb_on[i] = 0; sb_cnt[i] = 0;
      end
      q_head = 0; q_tail = 0; q_count = 0; slots = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        sss_pkg::REG_MAX_CONC: max_conc = v[4:0];
        sss_pkg::REG_SPINUP:   spin_len = v[7:0];
        sss_pkg::REG_STANDBY:  sb_len   = v;
        default: ;
      endcase
    endfunction

    function void push(sss_pkg::kind_e k, logic [3:0] d);
      res_t r;
      r.kind = k; r.dev = d; r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void grant(logic [3:0] d);
      slots = (slots + 1) & 31;
      pstate[d] = sss_pkg::PS_SPIN;
      spin_on[d] = 1;
      spin_cnt[d] = spin_len;
    endfunction

    function void note_input(sss_pkg::func_e f, logic [3:0] d, logic [2:0] ns);
      bit [sss_pkg::NumDevices-1:0] fresh;
      logic [3:0] g;
      fresh = '0;
      case (f)
        sss_pkg::FUNC_CMD: begin
          if (pstate[d] == sss_pkg::PS_STANDBY || pstate[d] == sss_pkg::PS_PASSED) begin
            if (slots < max_conc) begin
              grant(d);
              push(sss_pkg::KIND_PROCEED, d);
            end else begin
              // no free slot: blocked; queued if there is room, else device left as it was
              if (q_count < sss_pkg::FifoDepth) begin
                waitq[q_tail] = d;
                q_tail = (q_tail + 1) % sss_pkg::FifoDepth;
                q_count++;
                pstate[d] = sss_pkg::PS_WAITING;
              end
              push(sss_pkg::KIND_BLOCKED, d);
            end
          end else begin
            if (pstate[d] == sss_pkg::PS_SBWAIT) begin
              sb_on[d] = 1;
              sb_cnt[d] = sb_len;
            end
            push(sss_pkg::KIND_PROCEED, d);
          end
        end
        sss_pkg::FUNC_TICK: begin
          for (int i = 0; i < sss_pkg::NumDevices; i++) begin
            if (spin_on[i] && !fresh[i]) begin
              if (spin_cnt[i] <= 1) begin
                spin_on[i] = 0; spin_cnt[i] = 0;
                if (slots > 0) slots--;
                if (q_count > 0 && slots < max_conc) begin
                  g = waitq[q_head];
                  q_head = (q_head + 1) % sss_pkg::FifoDepth;
                  q_count--;
                  grant(g);
                  fresh[g] = 1'b1;
                  push(sss_pkg::KIND_UNBLOCK, g);
                end
              end else begin
                spin_cnt[i]--;
              end
            end
            if (sb_on[i]) begin
              if (sb_cnt[i] <= 1) begin
                sb_on[i] = 0; sb_cnt[i] = 0;
                pstate[i] = sss_pkg::PS_PASSED;
                push(sss_pkg::KIND_PASSED, 4'(i));
              end else begin
                sb_cnt[i]--;
              end
            end
          end
          push(sss_pkg::KIND_DONE, 4'd0);
        end
        sss_pkg::FUNC_SET: begin
          pstate[d] = ns;
          push(sss_pkg::KIND_DONE, 4'd0);
        end
        default: push(sss_pkg::KIND_DONE, 4'd0);
      endcase
      pending[$].last = 1'b1;
    endfunction

    function void check_result(logic [2:0] k, logic [3:0] d, logic l);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d dev=%0d last=%0d", $time, k, d, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind || d !== e.dev || l !== e.last) begin
        $display("%0t: mismatch expected kind=%0d dev=%0d last=%0d,", $time,
                 e.kind, e.dev, e.last);
        $display("%0t:          actual kind=%0d dev=%0d last=%0d", $time, k, d, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [3:0]  device_i = '0;
  logic [2:0]  new_state_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  device_res_o;
  logic        last_o;

  staggered_spinup_scheduler DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  spinup_scoreboard sb = new();

  // idling percentages for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  longint      cycles = 0;
  localparam longint CycleLimit = 2_000_000;

  // Output side: sample on the edge, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(kind_o, device_res_o, last_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One input transfer; gaps are inserted before the item, never mid-transfer.
  task automatic send_item(sss_pkg::func_e f, logic [3:0] d, logic [2:0] ns);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    device_i    <= d;
    new_state_i <= ns;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(f, d, ns);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    // a tick's done result can trail its scan; give the engine time to settle
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic set_regs(logic [4:0] mc, logic [7:0] sp, logic [15:0] st);
    write_cfg(sss_pkg::REG_MAX_CONC, 16'(mc));
    write_cfg(sss_pkg::REG_SPINUP, 16'(sp));
    write_cfg(sss_pkg::REG_STANDBY, st);
  endtask

  // Mostly commands to random disks and ticks; set-state mostly moves disks to standby or standby-wait.
  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)
      send_item(sss_pkg::FUNC_CMD, 4'($urandom), 3'd0);
    else if (r < 70)
      send_item(sss_pkg::FUNC_TICK, 4'($urandom), 3'($urandom));
    else if (r < 95)
      send_item(sss_pkg::FUNC_SET, 4'($urandom),
                ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(2) ? 1 : 5));
    else
      send_item(sss_pkg::FUNC_NOP, 4'($urandom), 3'($urandom));
  endtask

  initial begin
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fields at their extremes, every operation, queue overflow
    send_item(sss_pkg::FUNC_SET, 4'd0, 3'd7);
    send_item(sss_pkg::FUNC_CMD, 4'd0, 3'd7);      // unnamed state acts as other
    send_item(sss_pkg::FUNC_NOP, 4'd15, 3'd7);
    for (int i = 0; i < 16; i++) send_item(sss_pkg::FUNC_SET, 4'(i), sss_pkg::PS_STANDBY);
    drain();
    set_regs(5'd1, 8'd0, 16'd1);
    send_item(sss_pkg::FUNC_SET, 4'd15, sss_pkg::PS_SBWAIT);
    send_item(sss_pkg::FUNC_CMD, 4'd15, 3'd0);     // standby re-arm
    for (int i = 0; i < 15; i++) send_item(sss_pkg::FUNC_CMD, 4'(i), 3'd0);
    // requeue one disk until the wait queue is full: the last is not queued
    for (int i = 0; i < 3; i++) begin
      send_item(sss_pkg::FUNC_SET, 4'd3, sss_pkg::PS_PASSED);
      send_item(sss_pkg::FUNC_CMD, 4'd3, 3'd0);
    end
    for (int i = 0; i < 4; i++) send_item(sss_pkg::FUNC_TICK, 4'd0, 3'd0);
    drain();
    set_regs(5'd0, 8'd2, 16'd0);          // no slot after expiry
    for (int i = 0; i < 4; i++) send_item(sss_pkg::FUNC_TICK, 4'd0, 3'd0);
    drain();

    // Random phases: each phase its own idling and register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (ph)
        0: set_regs(5'd16, 8'd255, 16'd65535);
        1: set_regs(5'd1, 8'd1, 16'd0);
        2: set_regs(5'd2, 8'd3, 16'd2);
        3: set_regs(5'd31, 8'd5, 16'd4);
        default: set_regs(5'($urandom_range(1, 4)), 8'($urandom_range(0, 8)),
                          16'($urandom_range(0, 6)));
      endcase
      if (ph == 4) begin
        // long receiver hold-off so the block backs up into its input
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
          repeat (36) random_item();
        join
      end else begin
        repeat (36) random_item();
      end
      drain();                             // sender pauses until all results are in
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
